// ----- sv/ssr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_pkg
// Shared types, widths and constants of the stepper speed ramp controller.
// ----------------------------------------------------------------------------
package ssr_pkg;

  localparam int RELOAD_BITS  = 16;
  localparam int BASE_BITS    = 27;
  localparam int FREQ_BITS    = 16;
  localparam int STEP_BITS    = 10;
  localparam int KIND_BITS    = 3;
  localparam int CFG_IDX_BITS = 2;
  localparam int DIV_CNT_BITS = $clog2(BASE_BITS + 1);

  localparam logic [BASE_BITS-1:0]   CLK_HZ_RST    = BASE_BITS'(1014084);
  localparam logic [FREQ_BITS-1:0]   MIN_FREQ_RST  = FREQ_BITS'(100);
  localparam logic [STEP_BITS-1:0]   RAMP_STEP_RST = STEP_BITS'(10);
  localparam logic [RELOAD_BITS-1:0] RELOAD_RST    = RELOAD_BITS'(1000);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_CLK_HZ    = 2'd0,
    CFG_MIN_FREQ  = 2'd1,
    CFG_RAMP_STEP = 2'd2
  } cfg_reg_t;

  typedef enum logic [KIND_BITS-1:0] {
    K_TICK      = 3'd0,
    K_START     = 3'd1,
    K_CHANGE    = 3'd2,
    K_SOFT_STOP = 3'd3,
    K_HARD_STOP = 3'd4,
    K_SET_DIR   = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_START  = 2'd1,
    MODE_CHANGE = 2'd2,
    MODE_STOP   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIN_GO,
    ST_MIN_WAIT,
    ST_TGT_GO,
    ST_TGT_WAIT,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic accept;
    logic div_start;
    logic div_sel_tgt;
    logic cap_min;
    logic cap_tgt;
    logic apply;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  div_done;
    logic  out_free;
  } sts_t;

  // quotient to timer reload: q - 1, saturated, and 0 for q of 0
  function automatic logic [RELOAD_BITS-1:0] reload_sat(input logic [BASE_BITS-1:0] q);
    logic [BASE_BITS-1:0] qm1;
    qm1 = q - BASE_BITS'(1);
    if (q == '0) begin
      return '0;
    end else if (qm1 > BASE_BITS'({RELOAD_BITS{1'b1}})) begin
      return {RELOAD_BITS{1'b1}};
    end else begin
      return qm1[RELOAD_BITS-1:0];
    end
  endfunction

endpackage

// ----- sv/ssr_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ssr_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ssr_pkg::BASE_BITS-1:0]  dividend,
  input  logic [ssr_pkg::FREQ_BITS-1:0]  divisor,
  output logic                           done,
  output logic [ssr_pkg::BASE_BITS-1:0]  quotient
);
  import ssr_pkg::*;

  logic                    busy;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [FREQ_BITS-1:0]    rem;
  logic [FREQ_BITS-1:0]    dvsr;
  logic [BASE_BITS-1:0]    quo;
  logic [FREQ_BITS:0]      shifted;
  logic                    fits;

  assign shifted  = {rem, quo[BASE_BITS-1]};
  assign fits     = shifted >= {1'b0, dvsr};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= DIV_CNT_BITS'(BASE_BITS);
      end else if (busy) begin
        cnt <= cnt - DIV_CNT_BITS'(1);
        if (cnt == DIV_CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvsr <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= FREQ_BITS'(shifted - {1'b0, dvsr});
      end else begin
        rem <= shifted[FREQ_BITS-1:0];
      end
      quo <= {quo[BASE_BITS-2:0], fits};
    end
  end

endmodule

// ----- sv/ssr_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_ctrl
// Sequencer: accepts a request, runs the needed divisions, applies the update.
// ----------------------------------------------------------------------------
module ssr_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  input  logic [ssr_pkg::KIND_BITS-1:0] kind,
  output logic                          cmd_stall,
  input  ssr_pkg::sts_t                 sts,
  output ssr_pkg::cmd_t                 cmd
);
  import ssr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd_stall  = (state != ST_IDLE);
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd.accept = 1'b1;
          case (kind_t'(kind))
            K_START, K_SOFT_STOP: state_next = ST_MIN_GO;
            K_CHANGE:             state_next = ST_TGT_GO;
            default:              state_next = ST_APPLY;
          endcase
        end
      end
      ST_MIN_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_MIN_WAIT;
      end
      ST_MIN_WAIT: begin
        if (sts.div_done) begin
          cmd.cap_min = 1'b1;
          state_next  = (sts.kind == K_START) ? ST_TGT_GO : ST_APPLY;
        end
      end
      ST_TGT_GO: begin
        cmd.div_start   = 1'b1;
        cmd.div_sel_tgt = 1'b1;
        state_next      = ST_TGT_WAIT;
      end
      ST_TGT_WAIT: begin
        if (sts.div_done) begin
          cmd.cap_tgt = 1'b1;
          state_next  = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (sts.out_free) begin
          cmd.apply  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/ssr_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssr_dp
// Datapath: config registers, reload conversion, ramp state and result register.
// ----------------------------------------------------------------------------
module ssr_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [ssr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ssr_pkg::BASE_BITS-1:0]    cfg_data,
  input  logic [ssr_pkg::KIND_BITS-1:0]    kind,
  input  logic [ssr_pkg::FREQ_BITS-1:0]    target_freq,
  input  logic                             dir_in,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [ssr_pkg::RELOAD_BITS-1:0]  reload_value,
  output logic                             pulses_on,
  output logic                             driver_enable,
  output logic                             dir_out,
  output logic                             ramping,
  input  ssr_pkg::cmd_t                    cmd,
  output ssr_pkg::sts_t                    sts
);
  import ssr_pkg::*;

  logic [BASE_BITS-1:0]   clk_hz;
  logic [FREQ_BITS-1:0]   min_freq;
  logic [STEP_BITS-1:0]   ramp_step;

  kind_t                  kind_q;
  logic [FREQ_BITS-1:0]   freq_q;
  logic                   dir_q;

  logic [RELOAD_BITS-1:0] min_reload;
  logic [RELOAD_BITS-1:0] tgt_reload;

  logic [RELOAD_BITS-1:0] current_reload, current_reload_next;
  logic [RELOAD_BITS-1:0] goal_reload, goal_reload_next;
  mode_t                  ramp_mode, ramp_mode_next;
  logic                   output_running, output_running_next;
  logic                   enable_line, enable_line_next;
  logic                   direction_line, direction_line_next;

  logic                   div_done;
  logic [BASE_BITS-1:0]   div_quo;
  logic [FREQ_BITS-1:0]   div_dvsr;
  logic [RELOAD_BITS-1:0] step_ext;
  logic [RELOAD_BITS-1:0] diff;
  logic [RELOAD_BITS-1:0] ticked;

  assign div_dvsr = cmd.div_sel_tgt ? freq_q : min_freq;

  ssr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (clk_hz),
    .divisor  (div_dvsr),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign sts.kind     = kind_q;
  assign sts.div_done = div_done;
  assign sts.out_free = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      clk_hz    <= CLK_HZ_RST;
      min_freq  <= MIN_FREQ_RST;
      ramp_step <= RAMP_STEP_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CLK_HZ:    clk_hz    <= cfg_data;
        CFG_MIN_FREQ:  min_freq  <= cfg_data[FREQ_BITS-1:0];
        CFG_RAMP_STEP: ramp_step <= cfg_data[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // request latch and division results
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q <= kind_t'(kind);
      freq_q <= target_freq;
      dir_q  <= dir_in;
    end
    if (cmd.cap_min) begin
      min_reload <= (min_freq == '0) ? '0 : reload_sat(div_quo);
    end
    if (cmd.cap_tgt) begin
      tgt_reload <= (freq_q == '0) ? '0 : reload_sat(div_quo);
    end
  end

  // one ramp tick toward the goal
  always_comb begin
    step_ext = RELOAD_BITS'(ramp_step);
    diff     = '0;
    ticked   = current_reload;
    if (current_reload > goal_reload) begin
      diff   = current_reload - goal_reload;
      ticked = (diff <= step_ext) ? goal_reload : current_reload - step_ext;
    end else if (current_reload < goal_reload) begin
      diff   = goal_reload - current_reload;
      ticked = (diff <= step_ext) ? goal_reload : current_reload + step_ext;
    end
  end

  always_comb begin
    current_reload_next = current_reload;
    goal_reload_next    = goal_reload;
    ramp_mode_next      = ramp_mode;
    output_running_next = output_running;
    enable_line_next    = enable_line;
    direction_line_next = direction_line;
    case (kind_q)
      K_TICK: begin
        if (ramp_mode != MODE_IDLE) begin
          current_reload_next = ticked;
          if (ticked == goal_reload) begin
            if (ramp_mode == MODE_START) begin
              enable_line_next = 1'b1;
            end else if (ramp_mode == MODE_STOP) begin
              output_running_next = 1'b0;
            end
            ramp_mode_next = MODE_IDLE;
          end
        end
      end
      K_START: begin
        output_running_next = 1'b1;
        goal_reload_next    = tgt_reload;
        if (tgt_reload >= min_reload) begin
          current_reload_next = tgt_reload;
          enable_line_next    = 1'b1;
          ramp_mode_next      = MODE_IDLE;
        end else begin
          current_reload_next = min_reload;
          ramp_mode_next      = MODE_START;
        end
      end
      K_CHANGE: begin
        goal_reload_next = tgt_reload;
        ramp_mode_next   = (current_reload == tgt_reload) ? MODE_IDLE : MODE_CHANGE;
      end
      K_SOFT_STOP: begin
        goal_reload_next = min_reload;
        if (current_reload >= min_reload) begin
          output_running_next = 1'b0;
          ramp_mode_next      = MODE_IDLE;
        end else begin
          ramp_mode_next = MODE_STOP;
        end
      end
      K_HARD_STOP: begin
        output_running_next = 1'b0;
        ramp_mode_next      = MODE_IDLE;
      end
      K_SET_DIR: begin
        direction_line_next = dir_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_reload <= RELOAD_RST;
      goal_reload    <= RELOAD_RST;
      ramp_mode      <= MODE_IDLE;
      output_running <= 1'b0;
      enable_line    <= 1'b0;
      direction_line <= 1'b0;
    end else if (cmd.apply) begin
      current_reload <= current_reload_next;
      goal_reload    <= goal_reload_next;
      ramp_mode      <= ramp_mode_next;
      output_running <= output_running_next;
      enable_line    <= enable_line_next;
      direction_line <= direction_line_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.apply) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      reload_value  <= current_reload_next;
      pulses_on     <= output_running_next;
      driver_enable <= enable_line_next;
      dir_out       <= direction_line_next;
      ramping       <= (ramp_mode_next != MODE_IDLE);
    end
  end

endmodule

// ----- sv/stepper_speed_ramp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_speed_ramp
// Step-pulse period controller with a linear reload ramp.
//
// Requests (kind, target_freq, dir_in) arrive on cmd_valid / cmd_stall; each
// request gives exactly one result (reload_value, pulses_on, driver_enable,
// dir_out, ramping) on rsp_valid / rsp_stall, showing the state after it.
// One request is worked at a time. Tick, hard stop and set direction go
// straight to the apply state, which loads the result register once the
// result side is free. Change speed runs one frequency-to-reload division,
// soft stop one, start two; each division goes through a shared restoring
// divider, one quotient bit per cycle. After the result loads, the block is
// idle and takes the next request. The result register frees the request
// side: a new request is taken while a result waits, and the block holds
// its update until the receiver drops rsp_stall. Configuration writes
// (cfg_wr_en, cfg_index, cfg_data) go straight to the config registers.
// Synchronous reset loads the default registers, reload 1000, idle ramp,
// output and enable lines off; no result is pending after reset.
// ----------------------------------------------------------------------------
module stepper_speed_ramp (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [ssr_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [ssr_pkg::BASE_BITS-1:0]    cfg_data,
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  logic [ssr_pkg::KIND_BITS-1:0]    kind,
  input  logic [ssr_pkg::FREQ_BITS-1:0]    target_freq,
  input  logic                             dir_in,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output logic [ssr_pkg::RELOAD_BITS-1:0]  reload_value,
  output logic                             pulses_on,
  output logic                             driver_enable,
  output logic                             dir_out,
  output logic                             ramping
);
  import ssr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  ssr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .kind      (kind),
    .cmd_stall (cmd_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  ssr_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .kind          (kind),
    .target_freq   (target_freq),
    .dir_in        (dir_in),
    .rsp_valid     (rsp_valid),
    .rsp_stall     (rsp_stall),
    .reload_value  (reload_value),
    .pulses_on     (pulses_on),
    .driver_enable (driver_enable),
    .dir_out       (dir_out),
    .ramping       (ramping),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule
